// ===== rtl/belt_pkg.sv =====
// Shared types, constants and helper functions for the belt block cipher.
// Used by belt_round and belt_block_cipher through scoped names; no dependencies.
package belt_pkg;

  // Configuration register indexes
  localparam logic [1:0] KEY_WORD_0_IDX = 2'd0;
  localparam logic [1:0] KEY_WORD_1_IDX = 2'd1;
  localparam logic [1:0] KEY_WORD_2_IDX = 2'd2;
  localparam logic [1:0] KEY_WORD_3_IDX = 2'd3;

  localparam int unsigned NUM_ROUNDS = 8;
  localparam int unsigned ROT_A      = 5;
  localparam int unsigned ROT_B      = 13;
  localparam int unsigned ROT_C      = 21;

  // Working words of one item in flight
  typedef struct packed {
    logic        dec;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } belt_state_t;

  // Eight 32-bit key words theta1..theta8, index 0 is theta1
  typedef logic [7:0][31:0] belt_theta_t;

  // Standard H substitution
  localparam logic [7:0] HBOX [256] = '{
    8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,
    8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
    8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,
    8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
    8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,
    8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
    8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,
    8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
    8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,
    8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
    8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,
    8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
    8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,
    8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
    8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,
    8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
    8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,
    8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
    8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,
    8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
    8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,
    8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
    8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,
    8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
    8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,
    8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
    8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,
    8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
    8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,
    8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
    8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,
    8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
  };

  // G_r: byte-wise H substitution, then rotate left by r (r is always a constant)
  function automatic logic [31:0] gtrans(input logic [31:0] u, input int unsigned r);
    logic [31:0] s;
    s = {HBOX[u[31:24]], HBOX[u[23:16]], HBOX[u[15:8]], HBOX[u[7:0]]};
    return (s << r) | (s >> (32 - r));
  endfunction

  // Key word index for G step s (1..7) of round rnd.
  // Encrypt uses (s - rnd) mod 8, decrypt uses (-rnd - s) mod 8.
  function automatic logic [2:0] key_idx(input logic [3:0] rnd, input logic [2:0] s,
                                         input logic dec);
    logic [2:0] r3;
    r3 = rnd[2:0];
    return dec ? (3'd0 - r3 - s) : (s - r3);
  endfunction

endpackage

// ===== rtl/belt_block_cipher.sv =====
// Top level of the belt (STB 34.101.31) block cipher, fully unrolled pipeline.
// Depends on belt_pkg and belt_round.
//
// Usage:
//   Config port: cfg_we_i writes cfg_data_i into key word cfg_index_i (0..3)
//   at a rising edge; write only while no item is in flight.
//   Input channel: in_valid_i / in_stall_o carry mode_i (0 encrypt,
//   1 decrypt) and the 128-bit block as block_low_i / block_high_i.
//   Output channel: out_valid_o / out_stall_i carry result_low_o /
//   result_high_o. An item moves on an edge with valid high and stall low.
// Pipeline:
//   Eight rounds of three register stages each. One item is taken every
//   cycle while out_stall_i is low.
//   Each stage holds at most two dependent G transforms.
// Reset:
//   Clears all stage valid bits and sets the key words to zero.
// Stall:
//   Items stop in place; empty stages still fill, so inputs are taken until
//   every stage holds an item. Nothing is lost or repeated.
module belt_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_low_o,
  output logic [63:0] result_high_o
);

  localparam int unsigned NR = belt_pkg::NUM_ROUNDS;

  logic [63:0]           key0_q, key1_q, key2_q, key3_q;
  belt_pkg::belt_theta_t theta;

  logic                  v_chain [NR+1];
  logic                  s_chain [NR+1];
  belt_pkg::belt_state_t st_chain [NR+1];

  // Key word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= 64'd0;
      key1_q <= 64'd0;
      key2_q <= 64'd0;
      key3_q <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        belt_pkg::KEY_WORD_0_IDX: key0_q <= cfg_data_i;
        belt_pkg::KEY_WORD_1_IDX: key1_q <= cfg_data_i;
        belt_pkg::KEY_WORD_2_IDX: key2_q <= cfg_data_i;
        belt_pkg::KEY_WORD_3_IDX: key3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign theta = {key3_q, key2_q, key1_q, key0_q};

  // Input item into the chain
  assign v_chain[0]      = in_valid_i;
  assign in_stall_o      = s_chain[0];
  assign st_chain[0].dec = mode_i;
  assign st_chain[0].a   = block_low_i[31:0];
  assign st_chain[0].b   = block_low_i[63:32];
  assign st_chain[0].c   = block_high_i[31:0];
  assign st_chain[0].d   = block_high_i[63:32];

  // Eight rounds in a row
  for (genvar k = 0; k < NR; k++) begin : g_round
    belt_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .round_k_i (3'(k)),
      .theta_i   (theta),
      .valid_i   (v_chain[k]),
      .stall_o   (s_chain[k]),
      .state_i   (st_chain[k]),
      .valid_o   (v_chain[k+1]),
      .stall_i   (s_chain[k+1]),
      .state_o   (st_chain[k+1])
    );
  end

  assign s_chain[NR]  = out_stall_i;
  assign out_valid_o  = v_chain[NR];

  // Output word order depends on direction
  always_comb begin
    if (st_chain[NR].dec) begin
      result_low_o  = {st_chain[NR].a, st_chain[NR].c};
      result_high_o = {st_chain[NR].b, st_chain[NR].d};
    end else begin
      result_low_o  = {st_chain[NR].d, st_chain[NR].b};
      result_high_o = {st_chain[NR].c, st_chain[NR].a};
    end
  end

endmodule

// ===== rtl/belt_round.sv =====
// One belt round split into three pipeline stages with valid/stall flow.
// Depends on belt_pkg (state type, key type, G transform, key index).
module belt_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [2:0]            round_k_i,   // round position 0..7 in the chain
  input  belt_pkg::belt_theta_t theta_i,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  belt_pkg::belt_state_t state_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output belt_pkg::belt_state_t state_o
);

  logic                  va_q, vb_q, vc_q;
  belt_pkg::belt_state_t sa_q, sb_q, sc_q;
  belt_pkg::belt_state_t sa_d, sb_d, sc_d;
  logic                  rdy_a, rdy_b, rdy_c;

  // Round number seen by the item in a stage: k+1 encrypt, 8-k decrypt
  function automatic logic [3:0] rnd_of(input logic dec, input logic [2:0] k);
    return dec ? (4'd8 - {1'b0, k}) : ({1'b0, k} + 4'd1);
  endfunction

  logic [3:0] rnd_a, rnd_b, rnd_c;
  logic [31:0] e_w;

  assign rnd_a = rnd_of(state_i.dec, round_k_i);
  assign rnd_b = rnd_of(sa_q.dec, round_k_i);
  assign rnd_c = rnd_of(sb_q.dec, round_k_i);

  // Stage A: G steps 1, 2 and 3
  always_comb begin
    sa_d   = state_i;
    sa_d.b = state_i.b ^ belt_pkg::gtrans(
               state_i.a + theta_i[belt_pkg::key_idx(rnd_a, 3'd1, state_i.dec)],
               belt_pkg::ROT_A);
    sa_d.c = state_i.c ^ belt_pkg::gtrans(
               state_i.d + theta_i[belt_pkg::key_idx(rnd_a, 3'd2, state_i.dec)],
               belt_pkg::ROT_C);
    sa_d.a = state_i.a - belt_pkg::gtrans(
               sa_d.b + theta_i[belt_pkg::key_idx(rnd_a, 3'd3, state_i.dec)],
               belt_pkg::ROT_B);
  end

  // Stage B: G step 4 with round number, then G step 5
  always_comb begin
    sb_d   = sa_q;
    e_w    = belt_pkg::gtrans(
               sa_q.b + sa_q.c + theta_i[belt_pkg::key_idx(rnd_b, 3'd4, sa_q.dec)],
               belt_pkg::ROT_C) ^ {28'd0, rnd_b};
    sb_d.b = sa_q.b + e_w;
    sb_d.c = sa_q.c - e_w;
    sb_d.d = sa_q.d + belt_pkg::gtrans(
               sb_d.c + theta_i[belt_pkg::key_idx(rnd_b, 3'd5, sa_q.dec)],
               belt_pkg::ROT_B);
  end

  // Stage C: G steps 6 and 7, then the word swaps
  always_comb begin
    logic [31:0] nb, nc;
    nb     = sb_q.b ^ belt_pkg::gtrans(
               sb_q.a + theta_i[belt_pkg::key_idx(rnd_c, 3'd6, sb_q.dec)],
               belt_pkg::ROT_C);
    nc     = sb_q.c ^ belt_pkg::gtrans(
               sb_q.d + theta_i[belt_pkg::key_idx(rnd_c, 3'd7, sb_q.dec)],
               belt_pkg::ROT_A);
    sc_d     = sb_q;
    if (sb_q.dec) begin
      // a<->b, c<->d, then a<->d
      sc_d.a = nc;
      sc_d.b = sb_q.a;
      sc_d.c = sb_q.d;
      sc_d.d = nb;
    end else begin
      // a<->b, c<->d, then b<->c
      sc_d.a = nb;
      sc_d.b = sb_q.d;
      sc_d.c = sb_q.a;
      sc_d.d = nc;
    end
  end

  // A stage loads when empty or when its item moves on
  assign rdy_c   = !vc_q || !stall_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign stall_o = !rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy_a) sa_q <= sa_d;
    if (rdy_b) sb_q <= sb_d;
    if (rdy_c) sc_q <= sc_d;
  end

  assign valid_o = vc_q;
  assign state_o = sc_q;

endmodule
